>>> rtl/core/mptct_pkg.sv
// ----------------------------------------------------------------------------
// mptct_pkg
// Shared types and fixed constants for the mouse packet to cell tracker.
// ----------------------------------------------------------------------------
package mptct_pkg;

	// Width of a received byte and of the motion fields it carries
	localparam int unsigned BYTE_W = 8;

	// Width of the reported cell coordinates
	localparam int unsigned OUT_W = 16;

	// Bit of the first packet byte that is always set by the mouse
	localparam int unsigned SYNC_BIT = 3;

	// Cursor position after reset
	localparam int COL_RESET = 40;
	localparam int ROW_RESET = 12;

	// Position of the next byte within its three-byte packet
	typedef enum logic [2:0] {
		POS_HEADER = 3'b001,
		POS_X      = 3'b010,
		POS_Y      = 3'b100
	} pos_t;

endpackage

>>> rtl/core/mouse_packet_to_cell_tracker_core.sv
// ----------------------------------------------------------------------------
// mouse_packet_to_cell_tracker_core
// Frames mouse bytes into three-byte packets and tracks a cursor in cells.
// ----------------------------------------------------------------------------
// Path: a Y byte waits in the input register, then its result is registered.
// Throughput: one byte per cycle; a Y byte waits in the input register only
//   while the previous result is still held under out_stall.
// Reset: arst_n clears packet framing, residuals and the result valid, and
//   puts the cursor at column 40, row 12. The stored X byte is not reset.
// ----------------------------------------------------------------------------
module mouse_packet_to_cell_tracker_core #(
	parameter int COUNTS_PER_CELL_LOG2 = 3,
	parameter int CELL_WIDTH           = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,

	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [mptct_pkg::BYTE_W-1:0]            rx_byte,

	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [mptct_pkg::OUT_W-1:0]      cell_col,
	output logic signed [mptct_pkg::OUT_W-1:0]      cell_row
);

	// Residual keeps |r| < 2^K, so K+1 signed bits hold it
	localparam int RES_W = COUNTS_PER_CELL_LOG2 + 1;
	// residual + motion stays within -135..+134 at K = 3, ten signed bits leave margin
	localparam int SUM_W = 10;
	// Coordinate accumulator: wide enough for the cell range, the output and a carry
	localparam int ACC_W = ((CELL_WIDTH > int'(mptct_pkg::OUT_W)) ?
		CELL_WIDTH : int'(mptct_pkg::OUT_W)) + 1;

	localparam logic signed [SUM_W-1:0] ROUND_BIAS =
		SUM_W'((64'sd1 <<< COUNTS_PER_CELL_LOG2) - 64'sd1);
	localparam logic signed [ACC_W-1:0] CELL_MAX =
		ACC_W'((64'sd1 <<< (CELL_WIDTH - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] CELL_MIN = -CELL_MAX - ACC_W'(1);

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	logic                          valid_s1;
	logic [mptct_pkg::BYTE_W-1:0]  rx_byte_s1;
	logic                          in_fire;
	logic                          s1_advance;
	logic                          s1_result;

	// ------------------------------------------------------------------
	// Tracker state
	// ------------------------------------------------------------------
	mptct_pkg::pos_t               pos_q;
	logic [mptct_pkg::BYTE_W-1:0]  motion_x_q;
	logic signed [RES_W-1:0]       residual_x_q;
	logic signed [RES_W-1:0]       residual_y_q;
	logic signed [CELL_WIDTH-1:0]  col_q;
	logic signed [CELL_WIDTH-1:0]  row_q;

	// Result register
	logic                                  out_valid_q;
	logic signed [mptct_pkg::OUT_W-1:0]    cell_col_q;
	logic signed [mptct_pkg::OUT_W-1:0]    cell_row_q;

	// Handshake: a byte that makes no result always drains; a Y byte waits
	// only while a previous result is still held under stall.
	assign s1_result  = valid_s1 && (pos_q == mptct_pkg::POS_Y);
	assign s1_advance = valid_s1 && (!s1_result || !out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !s1_advance;
	assign in_fire    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// ------------------------------------------------------------------
	// Motion arithmetic: add residual, truncate toward zero by 2^K
	// ------------------------------------------------------------------
	logic signed [SUM_W-1:0]  sum_x, sum_y;
	logic signed [SUM_W-1:0]  biased_x, biased_y;
	logic signed [SUM_W-1:0]  quot_x, quot_y;
	logic signed [SUM_W-1:0]  rem_x, rem_y;
	logic signed [ACC_W-1:0]  acc_col, acc_row;
	logic signed [ACC_W-1:0]  sat_col, sat_row;

	assign sum_x = SUM_W'(residual_x_q) + SUM_W'(signed'(motion_x_q));
	assign sum_y = SUM_W'(residual_y_q) + SUM_W'(signed'(rx_byte_s1));

	// Negative sums get a bias of 2^K-1 so the arithmetic shift truncates toward zero
	assign biased_x = sum_x + (sum_x[SUM_W-1] ? ROUND_BIAS : '0);
	assign biased_y = sum_y + (sum_y[SUM_W-1] ? ROUND_BIAS : '0);
	assign quot_x   = biased_x >>> COUNTS_PER_CELL_LOG2;
	assign quot_y   = biased_y >>> COUNTS_PER_CELL_LOG2;
	assign rem_x    = sum_x - (quot_x <<< COUNTS_PER_CELL_LOG2);
	assign rem_y    = sum_y - (quot_y <<< COUNTS_PER_CELL_LOG2);

	// Move the cursor and clamp to the signed cell range
	assign acc_col = ACC_W'(col_q) + ACC_W'(quot_x);
	assign acc_row = ACC_W'(row_q) + ACC_W'(quot_y);

	always_comb begin
		if (acc_col > CELL_MAX) begin
			sat_col = CELL_MAX;
		end else if (acc_col < CELL_MIN) begin
			sat_col = CELL_MIN;
		end else begin
			sat_col = acc_col;
		end
		if (acc_row > CELL_MAX) begin
			sat_row = CELL_MAX;
		end else if (acc_row < CELL_MIN) begin
			sat_row = CELL_MIN;
		end else begin
			sat_row = acc_row;
		end
	end

	// ------------------------------------------------------------------
	// Packet framing and state update
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= mptct_pkg::POS_HEADER;
			residual_x_q <= '0;
			residual_y_q <= '0;
			col_q        <= CELL_WIDTH'(mptct_pkg::COL_RESET);
			row_q        <= CELL_WIDTH'(mptct_pkg::ROW_RESET);
		end else if (s1_advance) begin
			unique case (pos_q)
				mptct_pkg::POS_HEADER: begin
					// Drop bytes without the sync bit to regain alignment
					if (rx_byte_s1[mptct_pkg::SYNC_BIT]) begin
						pos_q <= mptct_pkg::POS_X;
					end
				end
				mptct_pkg::POS_X: begin
					pos_q <= mptct_pkg::POS_Y;
				end
				mptct_pkg::POS_Y: begin
					pos_q        <= mptct_pkg::POS_HEADER;
					residual_x_q <= rem_x[RES_W-1:0];
					residual_y_q <= rem_y[RES_W-1:0];
					col_q        <= sat_col[CELL_WIDTH-1:0];
					row_q        <= sat_row[CELL_WIDTH-1:0];
				end
				default: begin
					pos_q <= mptct_pkg::POS_HEADER;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && (pos_q == mptct_pkg::POS_X)) begin
			motion_x_q <= rx_byte_s1;
		end
	end

	// ------------------------------------------------------------------
	// Result register: hold under stall, load on each finished packet
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance && s1_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && s1_result) begin
			cell_col_q <= sat_col[mptct_pkg::OUT_W-1:0];
			cell_row_q <= sat_row[mptct_pkg::OUT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign cell_col  = cell_col_q;
	assign cell_row  = cell_row_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_pos_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(pos_q))
		else $error("packet position is not one-hot");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && s1_result && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_result_after_y: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_advance && s1_result) |=> out_valid_q)
		else $error("finished packet produced no result");

	a_pos_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_advance |=> $stable(pos_q))
		else $error("packet position moved without a byte");

	a_resync_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_advance && (pos_q == mptct_pkg::POS_HEADER) &&
			!rx_byte_s1[mptct_pkg::SYNC_BIT]) |=> (pos_q == mptct_pkg::POS_HEADER))
		else $error("unsynced header byte advanced framing");

endmodule
